// File: rtl/fixed_point_q24_8_alu_defines.svh
// Assertion macros for the fixed-point ALU checker.
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = WORD_BITS + FRAC_BITS;
  localparam int DEN_W     = WORD_BITS;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int LATENCY   = DIV_STEPS + 4;

  typedef enum logic [3:0] {
    FN_ADD    = 4'd0,
    FN_SUB    = 4'd1,
    FN_MUL    = 4'd2,
    FN_DIV    = 4'd3,
    FN_GT     = 4'd4,
    FN_LT     = 4'd5,
    FN_GE     = 4'd6,
    FN_LE     = 4'd7,
    FN_EQ     = 4'd8,
    FN_NE     = 4'd9,
    FN_MAX    = 4'd10,
    FN_MIN    = 4'd11,
    FN_INC    = 4'd12,
    FN_DEC    = 4'd13,
    FN_TO_INT = 4'd14
  } fpa_func_t;

  typedef struct packed {
    logic [3:0]                  func;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_value;
    logic                        compare_true;
    logic                        error_flag;
  } fpa_out_t;

  typedef struct packed {
    logic [3:0]           func;
    logic [WORD_BITS-1:0] simple_res;
    logic                 simple_cmp;
    logic                 simple_err;
    logic                 neg;
    logic                 a_neg;
    logic                 div_zero;
    logic [PROD_W-1:0]    prod;
  } fpa_tag_t;

endpackage

// File: rtl/fpa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side tag.
`timescale 1ns / 1ps
module fpa_div_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [fpa_pkg::NUM_W-1:0] in_num,
  input  logic [fpa_pkg::DEN_W-1:0] in_den,
  input  fpa_pkg::fpa_tag_t         in_tag,
  output logic                      out_valid,
  output logic [fpa_pkg::NUM_W-1:0] out_quo,
  output logic [fpa_pkg::DEN_W-1:0] out_rem,
  output logic [fpa_pkg::DEN_W-1:0] out_den,
  output fpa_pkg::fpa_tag_t         out_tag
);
  import fpa_pkg::*;

  logic                 valid_r [DIV_STEPS];
  logic [NUM_W-1:0]     num_r [DIV_STEPS];
  logic [NUM_W-1:0]     quo_r [DIV_STEPS];
  logic [DEN_W-1:0]     rem_r [DIV_STEPS];
  logic [DEN_W-1:0]     den_r [DIV_STEPS];
  fpa_tag_t             tag_r [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    fpa_tag_t         tag_in;
    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign num_in = in_num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = valid_r[i-1];
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign shifted = {rem_in, num_in[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_in};
    assign diff    = shifted - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[i] <= {num_in[NUM_W-2:0], 1'b0};
      quo_r[i] <= {quo_in[NUM_W-2:0], ge};
      rem_r[i] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      den_r[i] <= den_in;
      tag_r[i] <= tag_in;
    end
  end

  assign out_valid = valid_r[DIV_STEPS-1];
  assign out_quo   = quo_r[DIV_STEPS-1];
  assign out_rem   = rem_r[DIV_STEPS-1];
  assign out_den   = den_r[DIV_STEPS-1];
  assign out_tag   = tag_r[DIV_STEPS-1];

endmodule

// File: rtl/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU, fully pipelined.
// Path: input register, stage 2, the divider pipeline, rounding register, output register.
// Throughput: one item per cycle; the 40-stage divider pipeline sets the depth.
// Every operation takes the same path, so results leave in order.
// Synchronous reset flushes all valid bits and holds busy high while asserted.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fpa_pkg::fpa_in_t  in_item,
  output logic              out_strobe,
  output fpa_pkg::fpa_out_t out_item
);
  import fpa_pkg::*;

  localparam logic [WORD_BITS-1:0] MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PROD_W-1:0]    HALF  = PROD_W'(1) << (FRAC_BITS - 1);

  logic busy_r;
  logic s1_valid_r;
  fpa_in_t s1_item_r;
  logic s2_valid_r, s2_valid_nxt;
  fpa_tag_t s2_tag_r, s2_tag_nxt;
  logic [WORD_BITS-1:0] s2_ma_r, s2_mb_r, ma_nxt, mb_nxt;
  fpa_tag_t div_tag_in;
  logic d_valid;
  logic [NUM_W-1:0] d_quo;
  logic [DEN_W-1:0] d_rem, d_den;
  fpa_tag_t d_tag;
  logic r_valid_r;
  fpa_tag_t r_tag_r;
  logic [PROD_W-1:0] r_mag_r, r_mag_nxt;
  logic out_valid_r;
  fpa_out_t out_r, out_nxt;

  function automatic logic [WORD_BITS:0] sat_sum(input logic [WORD_BITS:0] s);
    logic [WORD_BITS:0] r;
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r = {1'b1, s[WORD_BITS] ? MIN_W : MAX_W};
    end else begin
      r = {1'b0, s[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s1_valid_r  <= start && !busy_r;
      s2_valid_r  <= s2_valid_nxt;
      r_valid_r   <= d_valid;
      out_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= in_item;
    s2_tag_r  <= s2_tag_nxt;
    s2_ma_r   <= ma_nxt;
    s2_mb_r   <= mb_nxt;
    r_tag_r   <= d_tag;
    r_mag_r   <= r_mag_nxt;
    out_r     <= out_nxt;
  end

  // Stage 2: simple ops, signs and magnitudes
  always_comb begin
    logic signed [WORD_BITS-1:0] a, b;
    logic [WORD_BITS:0] r;
    a = s1_item_r.operand_a;
    b = s1_item_r.operand_b;
    s2_valid_nxt = s1_valid_r;
    s2_tag_nxt = '0;
    s2_tag_nxt.func = s1_item_r.func;
    s2_tag_nxt.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    s2_tag_nxt.a_neg = a[WORD_BITS-1];
    s2_tag_nxt.div_zero = (b == '0);
    ma_nxt = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    mb_nxt = b[WORD_BITS-1] ? (~b + 1'b1) : b;
    r = '0;
    case (s1_item_r.func)
      FN_ADD: r = sat_sum({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
      FN_SUB: r = sat_sum({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
      FN_INC: r = sat_sum({a[WORD_BITS-1], a} + (WORD_BITS+1)'(1));
      FN_DEC: r = sat_sum({a[WORD_BITS-1], a} - (WORD_BITS+1)'(1));
      FN_GT: s2_tag_nxt.simple_cmp = a > b;
      FN_LT: s2_tag_nxt.simple_cmp = a < b;
      FN_GE: s2_tag_nxt.simple_cmp = a >= b;
      FN_LE: s2_tag_nxt.simple_cmp = a <= b;
      FN_EQ: s2_tag_nxt.simple_cmp = a == b;
      FN_NE: s2_tag_nxt.simple_cmp = a != b;
      FN_MAX: r = {1'b0, (a > b) ? a : b};
      FN_MIN: r = {1'b0, (a < b) ? a : b};
      FN_TO_INT: r = {1'b0, a >>> FRAC_BITS};
      default: r = '0;
    endcase
    s2_tag_nxt.simple_res = r[WORD_BITS-1:0];
    s2_tag_nxt.simple_err = r[WORD_BITS];
  end

  always_comb begin
    div_tag_in = s2_tag_r;
    div_tag_in.prod = PROD_W'(s2_ma_r) * PROD_W'(s2_mb_r);
  end

  fpa_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_num    ({s2_ma_r, {FRAC_BITS{1'b0}}}),
    .in_den    (s2_mb_r),
    .in_tag    (div_tag_in),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_rem   (d_rem),
    .out_den   (d_den),
    .out_tag   (d_tag)
  );

  // Rounding, half away from zero on magnitudes
  always_comb begin
    logic [PROD_W-1:0] p;
    logic rnd;
    p = d_tag.prod + HALF;
    rnd = d_rem >= (d_den - d_rem);
    if (d_tag.func == FN_MUL) begin
      r_mag_nxt = p >> FRAC_BITS;
    end else begin
      r_mag_nxt = PROD_W'(d_quo) + PROD_W'(rnd);
    end
  end

  // Saturate, apply sign, select
  always_comb begin
    logic [PROD_W-1:0] limit;
    logic over;
    logic [WORD_BITS-1:0] val;
    limit = r_tag_r.neg ? PROD_W'(MIN_W) : PROD_W'(MAX_W);
    over = r_mag_r > limit;
    val = over ? limit[WORD_BITS-1:0] : r_mag_r[WORD_BITS-1:0];
    out_nxt = '0;
    case (r_tag_r.func)
      FN_MUL: begin
        out_nxt.result_value = r_tag_r.neg ? (~val + 1'b1) : val;
        out_nxt.error_flag = over;
      end
      FN_DIV: begin
        if (r_tag_r.div_zero) begin
          out_nxt.result_value = r_tag_r.a_neg ? MIN_W : MAX_W;
          out_nxt.error_flag = 1'b1;
        end else begin
          out_nxt.result_value = r_tag_r.neg ? (~val + 1'b1) : val;
          out_nxt.error_flag = over;
        end
      end
      default: begin
        out_nxt.result_value = r_tag_r.simple_res;
        out_nxt.compare_true = r_tag_r.simple_cmp;
        out_nxt.error_flag = r_tag_r.simple_err;
      end
    endcase
  end

  assign out_strobe = out_valid_r;
  assign out_item = out_r;

endmodule

// File: rtl/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
`include "fixed_point_q24_8_alu_defines.svh"
module fpa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input fpa_pkg::fpa_out_t out_item
);
  import fpa_pkg::*;

  `FPA_ASSERT_ALWAYS(a_busy_in_reset, !rst_n |=> busy, "busy low right after reset")
  `FPA_ASSERT(a_strobe_has_item, out_strobe |-> $past(start && !busy, LATENCY), "result without item")
  `FPA_ASSERT(a_item_gives_strobe, (start && !busy) |-> ##LATENCY out_strobe, "item lost")
  `FPA_ASSERT(a_cmp_no_err, (out_strobe && out_item.compare_true) |-> (!out_item.error_flag && out_item.result_value == '0), "compare with value or error")

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// File: dv/fixed_point_q24_8_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random operations.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_tb;
  import fpa_pkg::*;

  localparam int MAX_PRINT = 10;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  fpa_in_t  in_item;
  logic     out_strobe;
  fpa_out_t out_item;

  fpa_in_t  pending_items[$];
  fpa_out_t expected_results[$];
  int       mismatches;
  int       send_idle_pct;

  fixed_point_q24_8_alu i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic [31:0] sat_word(logic neg);
    return neg ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // Bring a wide magnitude back into range; saturate and flag on overflow.
  function automatic logic [31:0] pack_mag(logic neg, logic [127:0] mag, ref logic err);
    logic [127:0] limit;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (mag > limit) begin
      err = 1'b1;
      mag = limit;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic fpa_out_t alu_result(fpa_in_t it);
    fpa_out_t r;
    logic signed [31:0] a, b;
    logic signed [32:0] s;
    logic [31:0] ma, mb;
    logic [127:0] prod, num, q, rem;
    logic err, neg;
    a = it.operand_a;
    b = it.operand_b;
    r = '0;
    err = 1'b0;
    neg = a[31] ^ b[31];
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (it.func)
      FN_ADD, FN_SUB, FN_INC, FN_DEC: begin
        case (it.func)
          FN_ADD:  s = a + b;
          FN_SUB:  s = a - b;
          FN_INC:  s = a + 1;
          default: s = a - 1;
        endcase
        if (s > 33'sh0_7fff_ffff || s < -33'sh0_8000_0000) begin
          err = 1'b1;
          r.result_value = sat_word(s[32]);
        end else begin
          r.result_value = s[31:0];
        end
      end
      FN_MUL: begin
        prod = 128'(ma) * 128'(mb);
        prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r.result_value = pack_mag(neg, prod, err);
      end
      FN_DIV: begin
        if (b == 0) begin
          err = 1'b1;
          r.result_value = sat_word(a[31]);
        end else begin
          num = 128'(ma) << FRAC_BITS;
          q = num / 128'(mb);
          rem = num % 128'(mb);
          if (rem >= 128'(mb) - rem) q = q + 1;
          r.result_value = pack_mag(neg, q, err);
        end
      end
      FN_GT:     r.compare_true = a > b;
      FN_LT:     r.compare_true = a < b;
      FN_GE:     r.compare_true = a >= b;
      FN_LE:     r.compare_true = a <= b;
      FN_EQ:     r.compare_true = a == b;
      FN_NE:     r.compare_true = a != b;
      FN_MAX:    r.result_value = (a > b) ? a : b;
      FN_MIN:    r.result_value = (a < b) ? a : b;
      FN_TO_INT: r.result_value = a >>> FRAC_BITS;
      default:   r = '0;
    endcase
    r.error_flag = err;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff - $urandom_range(0, 2);
      1:       return 32'h8000_0000 + $urandom_range(0, 2);
      2:       return 32'($signed($urandom_range(0, 8)) - 4);
      3:       return 32'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
      4:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      5:       return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [3:0] f, logic [31:0] a, logic [31:0] b);
    fpa_in_t it;
    it.func = f;
    it.operand_a = a;
    it.operand_b = b;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Scoreboard: predict on acceptance, compare on strobe
  always @(posedge clk) begin
    fpa_out_t want;
    if (rst_n && start && !busy)
      expected_results.push_back(alu_result(in_item));
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINT)
          $display("unexpected result %h", out_item);
      end else begin
        want = expected_results.pop_front();
        if (out_item.result_value !== want.result_value ||
            out_item.compare_true !== want.compare_true ||
            out_item.error_flag !== want.error_flag) begin
          mismatches++;
          if (mismatches <= MAX_PRINT)
            $display("mismatch: exp val %h cmp %b err %b, got val %h cmp %b err %b",
                     want.result_value, want.compare_true, want.error_flag,
                     out_item.result_value, out_item.compare_true, out_item.error_flag);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [31:0] ext[6];
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    mismatches = 0;
    send_idle_pct = 16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
    queue_op(FN_ADD, ext[0], 32'h1);
    queue_op(FN_SUB, ext[1], 32'h1);
    queue_op(FN_ADD, ext[1], ext[1]);
    queue_op(FN_MUL, ext[0], ext[0]);
    queue_op(FN_MUL, ext[1], ext[3]);
    queue_op(FN_MUL, 32'h180, 32'h1);
    queue_op(FN_MUL, 32'hffff_fe80, 32'h1);
    queue_op(FN_DIV, 32'h500, 32'h0);
    queue_op(FN_DIV, ext[1], 32'h0);
    queue_op(FN_DIV, ext[1], ext[3]);
    queue_op(FN_DIV, 32'h1, 32'h200);
    queue_op(FN_DIV, 32'hffff_ffff, 32'h200);
    queue_op(FN_DIV, ext[0], ext[4]);
    for (int f = FN_GT; f <= FN_MIN; f++) begin
      queue_op(4'(f), ext[1], ext[0]);
      queue_op(4'(f), ext[5], ext[5]);
    end
    queue_op(FN_INC, ext[0], ext[3]);
    queue_op(FN_DEC, ext[1], ext[3]);
    queue_op(FN_TO_INT, 32'hffff_ff01, ext[2]);
    queue_op(FN_TO_INT, ext[0], ext[1]);
    queue_op(4'd15, ext[0], ext[1]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 66 : 0;
      for (int i = 0; i < 135; i++)
        queue_op(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
